// ===== sv/nwr_pkg.sv =====
// nwr_pkg: shared types and constants for the NewReno window update block.
// Used by nwr_alu and newreno_window_update; depends on nothing.
package nwr_pkg;

  // Width of window, threshold and accumulator state.
  localparam int unsigned WIN_W = 40;
  localparam int unsigned DG_W  = 16;  // datagram size register
  localparam int unsigned IW_W  = 24;  // initial window register
  localparam int unsigned ACK_W = 20;  // acked bytes field
  localparam int unsigned CMD_W = 2;
  localparam int unsigned CNT_W = $clog2(WIN_W);

  localparam int unsigned IN_DATA_W  = ((ACK_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((2 * WIN_W + 1 + 7) / 8) * 8;

  localparam logic [DG_W-1:0] DG_RESET = DG_W'(1200);
  localparam logic [IW_W-1:0] IW_RESET = IW_W'(307200);

  // Event codes.
  localparam logic [CMD_W-1:0] CMD_ACK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CONG = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PERS = 2'd2;

  // Register indexes.
  localparam logic CFG_DATAGRAM = 1'b0;
  localparam logic CFG_INIT_WIN = 1'b1;

  // Operation of the shared adder.
  typedef enum logic {
    ALU_ADD_SAT,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    logic [WIN_W-1:0] res;  // saturated sum or raw difference
    logic             ge;   // subtract: a >= b
  } alu_out_t;

endpackage

// ===== sv/nwr_alu.sv =====
// nwr_alu: shared WIN_W-bit adder, saturating add or subtract with compare.
// Depends on nwr_pkg.
module nwr_alu (
  input  logic [nwr_pkg::WIN_W-1:0] a_i,
  input  logic [nwr_pkg::WIN_W-1:0] b_i,
  input  nwr_pkg::alu_op_e          op_i,
  output nwr_pkg::alu_out_t         out_o
);

  logic                      is_sub;
  logic [nwr_pkg::WIN_W-1:0] b_op;
  logic [nwr_pkg::WIN_W:0]   sum;

  assign is_sub = (op_i == nwr_pkg::ALU_SUB);
  assign b_op   = is_sub ? ~b_i : b_i;
  assign sum    = {1'b0, a_i} + {1'b0, b_op} + {{nwr_pkg::WIN_W{1'b0}}, is_sub};

  always_comb begin
    out_o.ge = sum[nwr_pkg::WIN_W];
    if (!is_sub && sum[nwr_pkg::WIN_W]) begin
      out_o.res = '1;  // clamp at window maximum
    end else begin
      out_o.res = sum[nwr_pkg::WIN_W-1:0];
    end
  end

endmodule

// ===== sv/newreno_window_update.sv =====
// newreno_window_update: NewReno window, threshold and avoidance accumulator on one adder.
// Unknown events go straight to finish; congestion and persistent events update state
// first; acks compare, then add (slow start) or accumulate and loop (avoidance, zero window
// grown first; bit-serial remainder at zero datagram size). Requests are taken only in idle;
// a result waiting in the output register stalls only the load of the following one.
// Reset (async, active low): datagram 1200, window 307200, threshold unset, acc 0.
module newreno_window_update (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // event requests
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [nwr_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [19:0] ack_len
  input  logic [nwr_pkg::CMD_W-1:0]      s_axis_tuser,   // [1:0] cmd
  // results
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [nwr_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // [39:0] window_bytes,
                                                         // [79:40] threshold_bytes,
                                                         // [80] phase
  // configuration
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [nwr_pkg::IW_W-1:0]       cfg_data_i
);

  localparam int unsigned W = nwr_pkg::WIN_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACK_CMP,   // window vs threshold: slow start or avoidance
    ST_ACK_SS,    // window += acked
    ST_ACK_CA,    // acc += acked
    ST_ZERO_WIN,  // zero window grows by one datagram
    ST_LOOP_CMP,  // acc -= window while acc >= window
    ST_LOOP_INC,  // window += datagram
    ST_MOD,       // acc %= window, one bit a cycle
    ST_CONG,
    ST_PERS,
    ST_FINISH     // phase compare and load of the output register
  } state_e;

  state_e                     state_q, state_d;
  logic [nwr_pkg::DG_W-1:0]   dg_q, dg_d;
  logic [W-1:0]               win_q, win_d;
  logic [W-1:0]               thr_q, thr_d;
  logic                       thr_vld_q, thr_vld_d;
  logic [W-1:0]               acc_q, acc_d;
  logic [W-1:0]               rem_q, rem_d;
  logic [nwr_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [nwr_pkg::ACK_W-1:0]  ack_q, ack_d;
  logic                       out_vld_q, out_vld_d;
  logic [nwr_pkg::OUT_DATA_W-1:0] out_q, out_d;

  logic [W-1:0]               alu_a, alu_b;
  nwr_pkg::alu_op_e           alu_op;
  nwr_pkg::alu_out_t          alu_out;

  logic [W-1:0]               floor2;
  logic [W-1:0]               half;
  logic [W-1:0]               mod_shift;
  logic                       mod_ge;
  logic                       in_fire;

  nwr_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .op_i  (alu_op),
    .out_o (alu_out)
  );

  assign floor2    = W'({dg_q, 1'b0});
  assign half      = win_q >> 1;
  // remainder step: shift in the next dividend bit; a carry out of the top
  // means the shifted value is surely at least the window
  assign mod_shift = {rem_q[W-2:0], acc_q[W-1]};
  assign mod_ge    = rem_q[W-1] | alu_out.ge;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // operand selection for the shared adder
  always_comb begin
    alu_a  = win_q;
    alu_b  = thr_q;
    alu_op = nwr_pkg::ALU_SUB;
    unique case (state_q)
      ST_ACK_SS: begin
        alu_a  = win_q;
        alu_b  = W'(ack_q);
        alu_op = nwr_pkg::ALU_ADD_SAT;
      end
      ST_ACK_CA: begin
        alu_a  = acc_q;
        alu_b  = W'(ack_q);
        alu_op = nwr_pkg::ALU_ADD_SAT;
      end
      ST_ZERO_WIN, ST_LOOP_INC: begin
        alu_a  = win_q;
        alu_b  = W'(dg_q);
        alu_op = nwr_pkg::ALU_ADD_SAT;
      end
      ST_LOOP_CMP: begin
        alu_a  = acc_q;
        alu_b  = win_q;
      end
      ST_MOD: begin
        alu_a  = mod_shift;
        alu_b  = win_q;
      end
      ST_CONG: begin
        alu_a  = half;
        alu_b  = floor2;
      end
      default: begin
        alu_a  = win_q;
        alu_b  = thr_q;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    dg_d      = dg_q;
    win_d     = win_q;
    thr_d     = thr_q;
    thr_vld_d = thr_vld_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    ack_d     = ack_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          ack_d = s_axis_tdata[nwr_pkg::ACK_W-1:0];
          unique case (s_axis_tuser)
            nwr_pkg::CMD_ACK:  state_d = ST_ACK_CMP;
            nwr_pkg::CMD_CONG: state_d = ST_CONG;
            nwr_pkg::CMD_PERS: state_d = ST_PERS;
            default:           state_d = ST_FINISH;  // unknown event: report only
          endcase
        end
      end
      ST_ACK_CMP: begin
        state_d = (!thr_vld_q || !alu_out.ge) ? ST_ACK_SS : ST_ACK_CA;
      end
      ST_ACK_SS: begin
        win_d   = alu_out.res;
        state_d = ST_FINISH;
      end
      ST_ACK_CA: begin
        acc_d = alu_out.res;
        if (win_q == '0) begin
          state_d = ST_ZERO_WIN;
        end else if (dg_q == '0) begin
          rem_d   = '0;
          cnt_d   = '0;
          state_d = ST_MOD;
        end else begin
          state_d = ST_LOOP_CMP;
        end
      end
      ST_ZERO_WIN: begin
        win_d = alu_out.res;
        if (dg_q == '0) begin
          acc_d   = '0;
          state_d = ST_FINISH;
        end else begin
          state_d = ST_LOOP_CMP;
        end
      end
      ST_LOOP_CMP: begin
        if (alu_out.ge) begin
          acc_d   = alu_out.res;
          state_d = ST_LOOP_INC;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_LOOP_INC: begin
        win_d   = alu_out.res;
        state_d = ST_LOOP_CMP;
      end
      ST_MOD: begin
        rem_d = mod_ge ? alu_out.res : mod_shift;
        acc_d = acc_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == nwr_pkg::CNT_W'(W - 1)) begin
          acc_d   = rem_d;
          state_d = ST_FINISH;
        end
      end
      ST_CONG: begin
        thr_d     = alu_out.ge ? half : floor2;
        win_d     = thr_d;
        thr_vld_d = 1'b1;
        acc_d     = '0;
        state_d   = ST_FINISH;
      end
      ST_PERS: begin
        thr_d     = floor2;
        win_d     = floor2;
        thr_vld_d = 1'b1;
        acc_d     = '0;
        state_d   = ST_FINISH;
      end
      ST_FINISH: begin
        // adder compares window against threshold for the phase bit
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d = 1'b1;
          out_d     = nwr_pkg::OUT_DATA_W'({thr_vld_q && alu_out.ge,
                                            thr_vld_q ? thr_q : {W{1'b0}},
                                            win_q});
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // configuration writes are expected only while idle; initial window reloads state
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nwr_pkg::CFG_DATAGRAM: dg_d = cfg_data_i[nwr_pkg::DG_W-1:0];
        nwr_pkg::CFG_INIT_WIN: begin
          win_d     = W'(cfg_data_i);
          thr_d     = '0;
          thr_vld_d = 1'b0;
          acc_d     = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      dg_q      <= nwr_pkg::DG_RESET;
      win_q     <= W'(nwr_pkg::IW_RESET);
      thr_q     <= '0;
      thr_vld_q <= 1'b0;
      acc_q     <= '0;
      rem_q     <= '0;
      cnt_q     <= '0;
      ack_q     <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      state_q   <= state_d;
      dg_q      <= dg_d;
      win_q     <= win_d;
      thr_q     <= thr_d;
      thr_vld_q <= thr_vld_d;
      acc_q     <= acc_d;
      rem_q     <= rem_d;
      cnt_q     <= cnt_d;
      ack_q     <= ack_d;
      out_vld_q <= out_vld_d;
      out_q     <= out_d;
    end
  end

endmodule

// ===== test/tb_newreno_window_update.sv =====
// tb_newreno_window_update: self-checking bench for the NewReno window update block.
// Needs nwr_pkg and newreno_window_update; drives event requests, checks every report
// against a cycle-free window tracker, and varies register settings and flow control.
`timescale 1ns / 100ps

module tb_newreno_window_update;

  localparam int unsigned W             = nwr_pkg::WIN_W;
  localparam int unsigned QUIET_LIMIT   = 20000;  // cycles with no request moving
  localparam int unsigned SETTLE_CYCLES = 8;      // block holds at most one event in flight
  localparam int unsigned BURST_LEN     = 150;
  localparam int unsigned NUM_PHASES    = 8;
  localparam bit [63:0]   WIN_MAX       = (64'd1 << W) - 64'd1;

  // Command code 3 is not defined in the package; the block must report state unchanged.
  localparam logic [nwr_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  // One report as it leaves on m_axis_tdata, fields in port order.
  typedef struct packed {
    bit [W-1:0] cwnd;
    bit [W-1:0] ssthresh;
    bit         phase;
  } window_report_t;

  // Tracks window, threshold and avoidance accumulator, and holds the reports
  // owed by the block in request order.
  class cwnd_book;
    bit [63:0]      dgram;
    bit [63:0]      init_win;
    bit [63:0]      cwnd;
    bit [63:0]      ssthresh;
    bit             ssthresh_set;
    bit [63:0]      acc;
    window_report_t pending_reports[$];
    int unsigned    errors;
    int unsigned    reports_seen;
    int unsigned    avoid_reports;
    int unsigned    event_count[4];

    function new();
      dgram    = 64'(nwr_pkg::DG_RESET);
      init_win = 64'(nwr_pkg::IW_RESET);
      reload_window();
    endfunction

    function void reload_window();
      cwnd         = init_win & WIN_MAX;
      ssthresh     = '0;
      ssthresh_set = 1'b0;
      acc          = '0;
    endfunction

    function bit [63:0] sat_add(bit [63:0] a, bit [63:0] b);
      bit [63:0] s;
      s = a + b;
      return (s < a || s > WIN_MAX) ? WIN_MAX : s;
    endfunction

    function void write_config(logic idx, logic [nwr_pkg::IW_W-1:0] value);
      if (idx == nwr_pkg::CFG_DATAGRAM) begin
        dgram = 64'(value[nwr_pkg::DG_W-1:0]);
      end else begin
        // initial window write also restarts the connection state
        init_win = 64'(value);
        reload_window();
      end
    endfunction

    function void note_event(logic [nwr_pkg::CMD_W-1:0] cmd, logic [nwr_pkg::ACK_W-1:0] bytes);
      window_report_t rpt;
      bit [63:0]      half;
      bit [63:0]      floor2;
      event_count[cmd]++;
      case (cmd)
        nwr_pkg::CMD_ACK: begin
          if (!ssthresh_set || cwnd < ssthresh) begin
            cwnd = sat_add(cwnd, 64'(bytes));          // slow start
          end else begin
            acc = sat_add(acc, 64'(bytes));
            if (cwnd == 0) begin
              // empty window: grow once with no subtraction
              cwnd = sat_add(cwnd, dgram);
              if (cwnd == 0) acc = '0;
            end
            if (cwnd != 0) begin
              if (dgram == 0) begin
                acc = acc % cwnd;                     // window cannot grow
              end else begin
                while (acc >= cwnd) begin
                  acc  = acc - cwnd;
                  cwnd = sat_add(cwnd, dgram);
                end
              end
            end
          end
        end
        nwr_pkg::CMD_CONG: begin
          floor2       = 2 * dgram;
          half         = cwnd >> 1;
          ssthresh     = (half < floor2) ? floor2 : half;
          ssthresh_set = 1'b1;
          cwnd         = ssthresh;
          acc          = '0;
        end
        nwr_pkg::CMD_PERS: begin
          cwnd         = 2 * dgram;
          ssthresh     = cwnd;
          ssthresh_set = 1'b1;
          acc          = '0;
        end
        default: ;  // unknown code leaves state alone
      endcase
      rpt.cwnd     = cwnd[W-1:0];
      rpt.ssthresh = ssthresh_set ? ssthresh[W-1:0] : '0;
      rpt.phase    = ssthresh_set && (cwnd >= ssthresh);
      pending_reports.push_back(rpt);
    endfunction

    function void check_report(logic [nwr_pkg::OUT_DATA_W-1:0] data);
      window_report_t want;
      window_report_t got;
      got.cwnd     = data[W-1:0];
      got.ssthresh = data[2*W-1:W];
      got.phase    = data[2*W];
      reports_seen++;
      if (got.phase) avoid_reports++;
      if (pending_reports.size() == 0) begin
        $display("%0t: report with no request outstanding: %h", $time, data);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      if (got.cwnd !== want.cwnd) begin
        $display("%0t: window_bytes expected %0d actual %0d", $time, want.cwnd, got.cwnd);
        errors++;
      end
      if (got.ssthresh !== want.ssthresh) begin
        $display("%0t: threshold_bytes expected %0d actual %0d", $time,
                 want.ssthresh, got.ssthresh);
        errors++;
      end
      if (got.phase !== want.phase) begin
        $display("%0t: phase expected %0d actual %0d", $time, want.phase, got.phase);
        errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT hookup. All inputs start at known values.
  // ---------------------------------------------------------------------------
  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [nwr_pkg::IN_DATA_W-1:0]    s_axis_tdata  = '0;   // [19:0] ack_len
  logic [nwr_pkg::CMD_W-1:0]        s_axis_tuser  = '0;   // [1:0] cmd
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [nwr_pkg::OUT_DATA_W-1:0]   m_axis_tdata;         // [39:0] window, [79:40] thresh,
                                                          // [80] phase
  logic                             cfg_we_i      = 1'b0;
  logic                             cfg_idx_i     = 1'b0;
  logic [nwr_pkg::IW_W-1:0]         cfg_data_i    = '0;

  cwnd_book    book;
  int unsigned send_idle_pct  = 0;  // chance per cycle that the sender holds off
  int unsigned recv_stall_pct = 0;  // chance per cycle that the receiver stalls
  int unsigned quiet_cycles   = 0;
  int unsigned settings_used  = 1;  // reset values count as the first

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  newreno_window_update DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Receiver: check the report moved at this edge, then pick next cycle's ready.
  // Signals read here are the values from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) book.check_report(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // Watchdog: any request moving on either side resets the count.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
    $display("newreno_window_update regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers. Each task starts and ends right after a rising edge; valid stays
  // high across back-to-back requests and drops only during idle cycles.
  // ---------------------------------------------------------------------------
  task automatic send_event(input logic [nwr_pkg::CMD_W-1:0] cmd,
                            input logic [nwr_pkg::ACK_W-1:0] bytes);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= nwr_pkg::IN_DATA_W'(bytes);
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    book.note_event(cmd, bytes);
  endtask

  // Stop sending and wait for every owed report.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (book.pending_reports.size() != 0) @(posedge clk_i);
  endtask

  // Registers change only with the block empty; the pad covers an event still in flight.
  task automatic apply_setting(input logic [nwr_pkg::DG_W-1:0] dg,
                               input logic [nwr_pkg::IW_W-1:0] iw);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= nwr_pkg::CFG_DATAGRAM;
    cfg_data_i <= nwr_pkg::IW_W'(dg);
    @(posedge clk_i);
    book.write_config(nwr_pkg::CFG_DATAGRAM, nwr_pkg::IW_W'(dg));
    cfg_idx_i  <= nwr_pkg::CFG_INIT_WIN;
    cfg_data_i <= iw;
    @(posedge clk_i);
    book.write_config(nwr_pkg::CFG_INIT_WIN, iw);
    cfg_we_i   <= 1'b0;
    settings_used++;
  endtask

  // Random events, mostly acks with congestion, persistent and unknown events sprinkled
  // in so that the window keeps cycling between slow start and avoidance. Halfway
  // through, the sender waits for the block to empty once.
  task automatic run_burst(input int unsigned n);
    int unsigned                 pick;
    logic [nwr_pkg::CMD_W-1:0]   cmd;
    logic [nwr_pkg::ACK_W-1:0]   bytes;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99, 0);
      if (pick < 78)      cmd = nwr_pkg::CMD_ACK;
      else if (pick < 88) cmd = nwr_pkg::CMD_CONG;
      else if (pick < 94) cmd = nwr_pkg::CMD_PERS;
      else                cmd = CMD_UNKNOWN;
      pick = $urandom_range(99, 0);
      if (pick < 50)      bytes = nwr_pkg::ACK_W'($urandom_range(4095, 0));
      else if (pick < 85) bytes = nwr_pkg::ACK_W'($urandom);
      else if (pick < 93) bytes = '1;
      else                bytes = '0;
      send_event(cmd, bytes);
      if (i == n / 2) drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [nwr_pkg::DG_W-1:0] dg_sel [NUM_PHASES];
    logic [nwr_pkg::IW_W-1:0] iw_sel [NUM_PHASES];

    book = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset settings: slow start with unset threshold, unknown code,
    // entry to avoidance, multi-step avoidance loop, floor of two datagrams.
    send_event(nwr_pkg::CMD_ACK,  20'h00000);
    send_event(nwr_pkg::CMD_ACK,  20'hFFFFF);
    send_event(CMD_UNKNOWN,       20'h55555);
    send_event(nwr_pkg::CMD_CONG, 20'hAAAAA);
    send_event(nwr_pkg::CMD_ACK,  20'd1000);
    send_event(nwr_pkg::CMD_ACK,  20'hFFFFF);
    send_event(CMD_UNKNOWN,       20'h00000);
    send_event(nwr_pkg::CMD_PERS, 20'h00000);
    send_event(nwr_pkg::CMD_ACK,  20'hFFFFF);
    send_event(nwr_pkg::CMD_CONG, 20'h00000);
    send_event(nwr_pkg::CMD_CONG, 20'h00000);
    send_event(nwr_pkg::CMD_CONG, 20'h00000);
    send_event(nwr_pkg::CMD_ACK,  20'd1);

    // Zero datagram and zero window: congestion leaves a zero window in
    // avoidance, so the next ack must clear the accumulator.
    apply_setting('0, '0);
    send_event(nwr_pkg::CMD_CONG, 20'h00000);
    send_event(nwr_pkg::CMD_ACK,  20'hAAAAA);
    send_event(nwr_pkg::CMD_PERS, 20'h00000);
    // Zero datagram, nonzero window: avoidance reduces the accumulator modulo the window.
    apply_setting('0, 24'd1000);
    send_event(nwr_pkg::CMD_CONG, 20'h00000);
    send_event(nwr_pkg::CMD_ACK,  20'hFFFFF);
    send_event(nwr_pkg::CMD_ACK,  20'h55555);
    // Register maximums.
    apply_setting('1, '1);
    send_event(nwr_pkg::CMD_ACK,  20'hFFFFF);
    send_event(nwr_pkg::CMD_CONG, 20'h00000);
    send_event(nwr_pkg::CMD_ACK,  20'hFFFFF);
    send_event(nwr_pkg::CMD_PERS, 20'h00000);
    send_event(nwr_pkg::CMD_ACK,  20'hFFFFF);

    // Random phases: settings include reset values, the legal minimums and
    // maximums, zero datagram size and random picks. Pacing mode cycles every phase.
    dg_sel[0] = nwr_pkg::DG_RESET;  iw_sel[0] = nwr_pkg::IW_RESET;
    dg_sel[1] = 16'd64;             iw_sel[1] = 24'd128;
    dg_sel[2] = '1;                 iw_sel[2] = '1;
    dg_sel[3] = '0;                 iw_sel[3] = 24'($urandom_range(200000, 128));
    dg_sel[4] = 16'd1460;           iw_sel[4] = 24'd14600;
    dg_sel[5] = 16'($urandom_range(65535, 64));
    iw_sel[5] = 24'($urandom_range(16777215, 128));
    dg_sel[6] = 16'($urandom_range(65535, 64));
    iw_sel[6] = 24'($urandom_range(16777215, 128));
    dg_sel[7] = 16'd64;             iw_sel[7] = '1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      apply_setting(dg_sel[p], iw_sel[p]);
      run_burst(BURST_LEN);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d acks, %0d congestion, %0d persistent, %0d unknown events",
             book.event_count[nwr_pkg::CMD_ACK], book.event_count[nwr_pkg::CMD_CONG],
             book.event_count[nwr_pkg::CMD_PERS], book.event_count[CMD_UNKNOWN]);
    $display("%0d reports checked (%0d in avoidance) over %0d register settings",
             book.reports_seen, book.avoid_reports, settings_used);
    if (book.errors == 0 && book.pending_reports.size() == 0) begin
      $display("newreno_window_update regression: pass");
    end else begin
      if (book.pending_reports.size() != 0)
        $display("%0t: %0d reports never arrived", $time, book.pending_reports.size());
      $display("newreno_window_update regression: fail");
    end
    $finish;
  end

endmodule
